### hdl/sgm_pkg.sv
package sgm_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 8;
    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 13;
    localparam int MAG_BITS       = 8;
    localparam int SQ_BITS        = 32;

    localparam logic [0:0] CFG_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WINDOW,
        ST_GRAD,
        ST_SQRT,
        ST_SCALE,
        ST_OUT
    } sgm_state_t;

    typedef struct packed {
        logic read;
        logic window;
        logic grad;
        logic sqrt_start;
        logic scale;
        logic restart;
    } sgm_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic emit;
        logic last;
        logic ignore;
    } sgm_status_t;

endpackage

### hdl/sgm_datapath.sv
module sgm_datapath #(
    parameter int MAX_WIDTH  = sgm_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = sgm_pkg::DEF_PIXEL_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sgm_pkg::sgm_cmd_t             ctl,
    output sgm_pkg::sgm_status_t          sts,
    input  logic                          in_cmd,
    input  logic [7:0]                    in_pixel,
    input  logic [sgm_pkg::WIDTH_BITS-1:0]  image_width,
    input  logic [sgm_pkg::HEIGHT_BITS-1:0] image_height,
    output logic [sgm_pkg::MAG_BITS-1:0]  magnitude
);
    import sgm_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PB = PIXEL_BITS;
    localparam int GB = PB + 4;
    localparam int SB = 2 * GB + 1;
    localparam int RB = GB + 1;
    localparam int WB = (WIDTH_BITS > AW + 1) ? WIDTH_BITS : AW + 1;
    localparam int RW = HEIGHT_BITS + 1;

    logic [PB-1:0] upper_mem [MAX_WIDTH];
    logic [PB-1:0] lower_mem [MAX_WIDTH];
    logic [PB-1:0] top_reg, mid_reg, pix_reg;
    logic [PB-1:0] win_reg [3][3];
    logic [PB-1:0] pix_in;
    logic [WB-1:0] in_col_reg, out_col_reg;
    logic [RW-1:0] in_row_reg;
    logic [HEIGHT_BITS-1:0] out_row_reg;
    logic [WB-1:0] w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic in_frame, emit, col0;
    logic emit_reg, col0_reg;
    logic [AW-1:0] addr;
    logic signed [GB:0] gx, gy;
    logic [GB-1:0] ax_reg, ay_reg;
    logic [SB-1:0] rem_reg;
    logic [SB-1:0] root_reg;
    logic [SB-1:0] bit_reg;
    logic [RB+5-1:0] prod;
    logic [31:0] quot_mul;
    logic [MAG_BITS-1:0] mag_reg;
    logic last_reg;

    always_comb begin
        w_eff = WB'(image_width);
        if (image_width == '0) w_eff = WB'(1);
        if (WB'(image_width) > WB'(MAX_WIDTH)) w_eff = WB'(MAX_WIDTH);
        h_eff = (image_height == '0) ? HEIGHT_BITS'(1) : image_height;
    end

    assign pix_in = PB'(in_pixel);
    assign in_frame = in_row_reg < RW'(h_eff);
    assign addr = in_col_reg[AW-1:0];
    assign emit = (in_row_reg >= RW'(2)) ||
                  (in_row_reg == RW'(1) && in_col_reg != '0);
    assign col0 = (in_col_reg == '0);
    assign sts.emit = emit_reg;
    assign sts.ignore = in_frame && (in_cmd == CMD_DRAIN);
    assign sts.last = last_reg;
    assign sts.sqrt_done = (bit_reg == '0);
    assign magnitude = mag_reg;

    always_ff @(posedge aclk) begin
        if (ctl.read) begin
            top_reg <= (in_row_reg >= RW'(2)) ? upper_mem[addr] : '0;
            mid_reg <= (in_row_reg >= RW'(1)) ? lower_mem[addr] : '0;
            pix_reg <= in_frame ? pix_in : '0;
            upper_mem[addr] <= lower_mem[addr];
            lower_mem[addr] <= in_frame ? pix_in : '0;
        end
    end

    assign gx = $signed({2'b0, win_reg[0][0]}) + $signed({1'b0, win_reg[1][0], 1'b0})
              + $signed({2'b0, win_reg[2][0]}) - $signed({2'b0, win_reg[0][2]})
              - $signed({1'b0, win_reg[1][2], 1'b0}) - $signed({2'b0, win_reg[2][2]});
    assign gy = $signed({2'b0, win_reg[0][0]}) + $signed({1'b0, win_reg[0][1], 1'b0})
              + $signed({2'b0, win_reg[0][2]}) - $signed({2'b0, win_reg[2][0]})
              - $signed({1'b0, win_reg[2][1], 1'b0}) - $signed({2'b0, win_reg[2][2]});

    logic [SB-1:0] sq_sum;
    assign sq_sum = SB'(ax_reg * ax_reg) + SB'(ay_reg * ay_reg);

    logic [SB-1:0] trial;
    assign trial = root_reg + bit_reg;
    assign prod = (RB+5)'(root_reg[RB-1:0]) * (RB+5)'(17);
    // divide by 24: drop three bits, then divide by 3 through the reciprocal
    assign quot_mul = 32'(prod[RB+4:3]) * 32'd43691;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.restart) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++) win_reg[r][c] <= '0;
            in_col_reg <= '0;
            in_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            bit_reg <= '0;
            last_reg <= 1'b0;
            emit_reg <= 1'b0;
            col0_reg <= 1'b0;
        end else begin
            if (ctl.window) begin
                emit_reg <= emit;
                col0_reg <= col0;
                if (col0) begin
                    for (int r = 0; r < 3; r++) begin
                        win_reg[r][0] <= win_reg[r][1];
                        win_reg[r][1] <= win_reg[r][2];
                        win_reg[r][2] <= '0;
                    end
                end else begin
                    for (int r = 0; r < 3; r++) begin
                        win_reg[r][0] <= win_reg[r][1];
                        win_reg[r][1] <= win_reg[r][2];
                    end
                    win_reg[0][2] <= top_reg;
                    win_reg[1][2] <= mid_reg;
                    win_reg[2][2] <= pix_reg;
                end
                if (in_col_reg + WB'(1) >= w_eff) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + RW'(1);
                end else begin
                    in_col_reg <= in_col_reg + WB'(1);
                end
                if (emit) begin
                    last_reg <= (out_row_reg + HEIGHT_BITS'(1) >= h_eff) &&
                                (out_col_reg + WB'(1) >= w_eff);
                    if (out_col_reg + WB'(1) >= w_eff) begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + HEIGHT_BITS'(1);
                    end else begin
                        out_col_reg <= out_col_reg + WB'(1);
                    end
                end
            end
            if (ctl.grad) begin
                ax_reg <= gx[GB] ? GB'(-gx) : GB'(gx);
                ay_reg <= gy[GB] ? GB'(-gy) : GB'(gy);
                if (col0_reg) begin
                    for (int r = 0; r < 3; r++) begin
                        win_reg[r][0] <= '0;
                        win_reg[r][1] <= '0;
                    end
                    win_reg[0][2] <= top_reg;
                    win_reg[1][2] <= mid_reg;
                    win_reg[2][2] <= pix_reg;
                end
            end
            if (ctl.sqrt_start) begin
                rem_reg <= sq_sum;
                root_reg <= '0;
                bit_reg <= SB'(1) << (2 * ((SB - 1) / 2));
            end else if (bit_reg != '0) begin
                if (rem_reg >= trial) begin
                    rem_reg <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            if (ctl.scale) begin
                mag_reg <= (quot_mul[31:17] > 15'd255) ? '1 : quot_mul[17 +: MAG_BITS];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (aresetn && ctl.window)
            assert (!(ctl.grad || ctl.read)) else $error("overlapping datapath commands");
    end

endmodule

### hdl/sgm_control.sv
module sgm_control (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 cfg_write,
    input  sgm_pkg::sgm_status_t sts,
    output sgm_pkg::sgm_cmd_t    ctl
);
    import sgm_pkg::*;

    sgm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        ctl = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        ctl.restart = cfg_write;
        case (state_reg)
            ST_IDLE: begin
                s_ready = !cfg_write;
                if (s_valid && !cfg_write && !sts.ignore) begin
                    ctl.read = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                ctl.window = 1'b1;
                state_next = ST_WINDOW;
            end
            ST_WINDOW: begin
                ctl.grad = 1'b1;
                state_next = sts.emit ? ST_GRAD : ST_IDLE;
            end
            ST_GRAD: begin
                ctl.sqrt_start = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (sts.sqrt_done) state_next = ST_SCALE;
            end
            ST_SCALE: begin
                ctl.scale = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    ctl.restart = cfg_write || sts.last;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### hdl/sobel_gradient_magnitude.sv
// Flow: an input transfer is read, shifted into the window and turned into a gradient,
// then passes through the iterative square root and a scale step before result valid.
// When an item yields a result, no new input is taken until that result is accepted.
// Items with no result return to idle after the gradient step; a drain ignored during the frame is taken in idle.
// Reset: synchronous active-low aresetn clears counters, window and controller;
// row stores are not cleared, unwritten entries are masked by row count.
module sobel_gradient_magnitude #(
    parameter int MAX_WIDTH  = sgm_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = sgm_pkg::DEF_PIXEL_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_pixel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_magnitude,
    output logic        m_frame_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import sgm_pkg::*;

    sgm_cmd_t    ctl;
    sgm_status_t sts;
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;
    assign m_frame_last = sts.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_BITS'(640);
            height_reg <= HEIGHT_BITS'(480);
        end else if (cfg_valid) begin
            if (cfg_index == CFG_WIDTH) width_reg <= cfg_data[WIDTH_BITS-1:0];
            else height_reg <= cfg_data;
        end
    end

    sgm_control u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .cfg_write, .sts, .ctl
    );

    sgm_datapath #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_dp (
        .aclk, .aresetn, .ctl, .sts,
        .in_cmd(s_cmd), .in_pixel(s_pixel),
        .image_width(width_reg), .image_height(height_reg),
        .magnitude(m_magnitude)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_magnitude)) else $error("result changed");

endmodule
